// File: hdl/lkv_pkg.sv
package lkv_pkg;

    // Field widths
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Default store depth and the capacity value after reset
    localparam int ENTRIES_DEF = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Operation codes carried in the input tuser
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Broadcast control from the top level to every cell of the row
    typedef struct packed {
        logic load;   // an item is taken this cycle
        logic hit;    // the key is present somewhere in the row
        logic put;    // the item is a put
        logic fill;   // a miss put takes a free place instead of evicting
    } t_cell_ctl;

endpackage

// File: hdl/lkv_cell.sv
module lkv_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkv_pkg::t_cell_ctl          i_ctl,
    input  logic [lkv_pkg::KEY_W-1:0]   i_probe_key,
    input  logic [lkv_pkg::KEY_W-1:0]   i_prev_key,
    input  logic [lkv_pkg::DATA_W-1:0]  i_prev_value,
    input  logic                        i_prev_valid,
    input  logic                        i_match_above,
    input  logic [lkv_pkg::DATA_W-1:0]  i_data_above,
    output logic [lkv_pkg::KEY_W-1:0]   o_key,
    output logic [lkv_pkg::DATA_W-1:0]  o_value,
    output logic                        o_valid,
    output logic                        o_match_chain,
    output logic [lkv_pkg::DATA_W-1:0]  o_data_chain
);
    import lkv_pkg::*;

    logic              r_valid;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_value;
    logic              w_match;
    logic              w_move;

    // Compare the probe key against this place
    assign w_match = r_valid && (r_key == i_probe_key);

    // Pass match and hit data on towards the most recent end
    assign o_match_chain = w_match | i_match_above;
    assign o_data_chain  = (w_match ? r_value : '0) | i_data_above;

    // Take the neighbour's entry when this place ages by one
    always_comb begin
        if (i_ctl.hit) begin
            w_move = i_ctl.load & o_match_chain;
        end else begin
            w_move = i_ctl.load & i_ctl.put & (i_ctl.fill ? i_prev_valid : r_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_move) begin
            r_valid <= 1'b1;
        end
    end

    // Payload holds no reset
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// File: hdl/lru_key_value_cache_core.sv
// An accepted input beat leaves its result beat in the output register in the next cycle.
// Throughput: one beat per cycle while m_axis_tready takes results; lookup and recency update run at once.
// The row keeps entries ordered by age, so a hit or insert is one shift towards the old end.
// Reset (synchronous, active low) empties the row, clears the occupancy count and
// sets capacity to 16; key and value payload registers are not cleared.
module lru_key_value_cache_core #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [lkv_pkg::CAP_W-1:0]  i_cfg_wr_data,     // capacity
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [63:0]                s_axis_tdata,      // [31:0] key, [63:32] data_in
    input  logic                       s_axis_tuser,      // [0] op
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [31:0]                m_axis_tdata,      // [31:0] data_out
    output logic                       m_axis_tuser       // [0] found
);
    import lkv_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0]  r_cap;
    logic [CW-1:0]     r_occ;
    logic              r_m_valid;
    logic              r_m_found;
    logic [DATA_W-1:0] r_m_data;

    logic              w_accept;
    logic              w_op;
    logic [KEY_W-1:0]  w_key;
    logic [DATA_W-1:0] w_data_in;
    logic              w_hit;
    logic [DATA_W-1:0] w_hit_data;
    logic [LW-1:0]     w_cap_ext;
    logic [LW-1:0]     w_limit;
    logic              w_fill;
    t_cell_ctl         w_ctl;
    logic [ENTRIES-1:0] w_valid_vec;

    logic [KEY_W-1:0]  w_ch_key   [0:ENTRIES];
    logic [DATA_W-1:0] w_ch_value [0:ENTRIES];
    logic              w_ch_valid [0:ENTRIES];
    logic              w_mchain   [0:ENTRIES];
    logic [DATA_W-1:0] w_dchain   [0:ENTRIES];

    // Unpack the input beat
    assign w_op      = s_axis_tuser;
    assign w_key     = s_axis_tdata[KEY_W-1:0];
    assign w_data_in = s_axis_tdata[KEY_W+DATA_W-1:KEY_W];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Saturate capacity to 1 .. ENTRIES
    assign w_cap_ext = LW'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            w_limit = LW'(1);
        end else if (w_cap_ext > LW'(ENTRIES)) begin
            w_limit = LW'(ENTRIES);
        end else begin
            w_limit = w_cap_ext;
        end
    end
    assign w_fill = LW'(r_occ) < w_limit;

    // Hit result comes off the most recent end of the row
    assign w_hit      = w_mchain[0];
    assign w_hit_data = w_dchain[0];

    assign w_ctl.load = w_accept;
    assign w_ctl.hit  = w_hit;
    assign w_ctl.put  = (w_op == OP_PUT);
    assign w_ctl.fill = w_fill;

    // Front of the row: the entry that becomes most recent
    assign w_ch_key[0]   = w_key;
    assign w_ch_value[0] = (w_op == OP_GET) ? w_hit_data : w_data_in;
    assign w_ch_valid[0] = 1'b1;
    assign w_mchain[ENTRIES] = 1'b0;
    assign w_dchain[ENTRIES] = '0;

    // Row of cells, index 0 most recent
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lkv_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_probe_key   (w_key),
            .i_prev_key    (w_ch_key[g]),
            .i_prev_value  (w_ch_value[g]),
            .i_prev_valid  (w_ch_valid[g]),
            .i_match_above (w_mchain[g+1]),
            .i_data_above  (w_dchain[g+1]),
            .o_key         (w_ch_key[g+1]),
            .o_value       (w_ch_value[g+1]),
            .o_valid       (w_ch_valid[g+1]),
            .o_match_chain (w_mchain[g]),
            .o_data_chain  (w_dchain[g])
        );
        assign w_valid_vec[g] = w_ch_valid[g+1];
    end

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap <= i_cfg_wr_data;
        end
    end

    // Count entries; grow only on a miss put into a free place
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (w_accept && (w_op == OP_PUT) && !w_hit && w_fill) begin
            r_occ <= r_occ + CW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_found <= w_hit;
            r_m_data  <= (w_hit && (w_op == OP_GET)) ? w_hit_data : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_found;
    assign m_axis_tdata  = r_m_data;

    // Occupancy tracks the number of valid places
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_occ))
        else $error("occupancy count differs from valid places");

    // Valid places stay packed at the most recent end
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_vec & (w_valid_vec + ENTRIES'(1))) == '0)
        else $error("valid places not contiguous");

    // Every accepted beat leaves a result beat in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_m_valid)
        else $error("accepted beat gave no result");

endmodule
